>>> src/bcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Widths, types and index tables shared by the barycentric solver.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int ADJ_W       = 2 * COORD_WIDTH + 1;
  localparam int TERM_W      = 3 * COORD_WIDTH + 1;
  localparam int SUM_W       = 3 * COORD_WIDTH + 3;
  localparam int WEIGHT_W    = 32;
  localparam int FRAC_SHIFT  = 16;
  localparam int QBITS       = WEIGHT_W - 1;
  localparam int REM_W       = SUM_W + QBITS + 1;
  localparam int OVF_SHIFT   = QBITS - FRAC_SHIFT;

  localparam logic [WEIGHT_W-1:0] SAT_POS = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] SAT_NEG = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WEIGHT_W-1:0]    weight_t;

  // adj[i] = e[a]*e[b] - e[c]*e[d], matrix rows are coordinates
  localparam int ADJ_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic [2:0][SUM_W-1:0] n_mag;
    logic [SUM_W-1:0]      d_mag;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic                  zero;
  } div_req_t;

endpackage

>>> src/bcs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_in_if
// Input channel: three vertices and a query point.
// ----------------------------------------------------------------------------
interface bcs_in_if import bcs_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t vertex_a_x, vertex_a_y, vertex_a_z;
  coord_t vertex_b_x, vertex_b_y, vertex_b_z;
  coord_t vertex_c_x, vertex_c_y, vertex_c_z;
  coord_t target_x, target_y, target_z;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, target_x, target_y,
           target_z,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, target_x, target_y,
           target_z,
    output ready
  );
endinterface

>>> src/bcs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_out_if
// Output channel: three weights and the singular flag.
// ----------------------------------------------------------------------------
interface bcs_out_if import bcs_pkg::*;;
  logic    valid;
  logic    ready;
  weight_t weight_a, weight_b, weight_c;
  logic    singular;

  modport source (output valid, weight_a, weight_b, weight_c, singular, input ready);
  modport sink (input valid, weight_a, weight_b, weight_c, singular, output ready);
endinterface

>>> src/bcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_front
// Six-stage pipe: adjugate, determinant, numerators, magnitudes, range check.
// ----------------------------------------------------------------------------
module bcs_front import bcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bcs_in_if.sink   in_i,
  output div_req_t req_o,
  output logic     req_valid_o,
  input  logic     req_ready_i
);

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;
  logic [NS-1:0] v_in;

  assign adv[NS-1] = !v_q[NS-1] || req_ready_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign v_in = {v_q[NS-2:0], in_i.valid};
  assign in_i.ready  = adv[0];
  assign req_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 1: capture
  coord_t e_q [9];
  coord_t t1_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      e_q[0] <= in_i.vertex_a_x; e_q[1] <= in_i.vertex_b_x; e_q[2] <= in_i.vertex_c_x;
      e_q[3] <= in_i.vertex_a_y; e_q[4] <= in_i.vertex_b_y; e_q[5] <= in_i.vertex_c_y;
      e_q[6] <= in_i.vertex_a_z; e_q[7] <= in_i.vertex_b_z; e_q[8] <= in_i.vertex_c_z;
      t1_q[0] <= in_i.target_x;  t1_q[1] <= in_i.target_y;  t1_q[2] <= in_i.target_z;
    end
  end

  // stage 2: cofactor products
  logic signed [PROD_W-1:0] p_q [9][2];
  coord_t r2_q [3];
  coord_t t2_q [3];
  for (genvar i = 0; i < 9; i++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (adv[1]) begin
        p_q[i][0] <= e_q[ADJ_IDX[i][0]] * e_q[ADJ_IDX[i][1]];
        p_q[i][1] <= e_q[ADJ_IDX[i][2]] * e_q[ADJ_IDX[i][3]];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int j = 0; j < 3; j++) begin
        r2_q[j] <= e_q[j];
        t2_q[j] <= t1_q[j];
      end
    end
  end

  // stage 3: adjugate
  logic signed [ADJ_W-1:0] adj_q [9];
  coord_t r3_q [3];
  coord_t t3_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < 9; i++) begin
        adj_q[i] <= ADJ_W'(p_q[i][0]) - ADJ_W'(p_q[i][1]);
      end
      for (int j = 0; j < 3; j++) begin
        r3_q[j] <= r2_q[j];
        t3_q[j] <= t2_q[j];
      end
    end
  end

  // stage 4: determinant and numerator terms
  logic signed [TERM_W-1:0] dp_q [3];
  logic signed [TERM_W-1:0] np_q [9];
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int j = 0; j < 3; j++) begin
        dp_q[j] <= TERM_W'(r3_q[j]) * TERM_W'(adj_q[3*j]);
        for (int i = 0; i < 3; i++) begin
          np_q[3*i+j] <= TERM_W'(adj_q[3*i+j]) * TERM_W'(t3_q[j]);
        end
      end
    end
  end

  // stage 5: sums
  logic signed [SUM_W-1:0] det_q;
  logic signed [SUM_W-1:0] num_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      det_q <= SUM_W'(dp_q[0]) + SUM_W'(dp_q[1]) + SUM_W'(dp_q[2]);
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= SUM_W'(np_q[3*i]) + SUM_W'(np_q[3*i+1]) + SUM_W'(np_q[3*i+2]);
      end
    end
  end

  // stage 6: signs, magnitudes, quotient range check
  div_req_t         req_d;
  div_req_t         req_q;
  logic [SUM_W-1:0] d_abs;
  always_comb begin
    d_abs = det_q[SUM_W-1] ? SUM_W'(-det_q) : SUM_W'(det_q);
    req_d.d_mag = d_abs;
    req_d.zero  = (det_q == '0);
    for (int i = 0; i < 3; i++) begin
      req_d.n_mag[i] = num_q[i][SUM_W-1] ? SUM_W'(-num_q[i]) : SUM_W'(num_q[i]);
      req_d.neg[i]   = num_q[i][SUM_W-1] ^ det_q[SUM_W-1];
      req_d.ovf[i]   = (SUM_W+OVF_SHIFT)'(req_d.n_mag[i])
                       >= ((SUM_W+OVF_SHIFT)'(d_abs) << OVF_SHIFT);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      req_q <= req_d;
    end
  end
  assign req_o = req_q;

endmodule

>>> src/bcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_div
// Restoring divider, one quotient bit per stage for three lanes, then
// sign, saturation and the output register.
// ----------------------------------------------------------------------------
module bcs_div import bcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  bcs_out_if.source out_o
);

  localparam int NS = QBITS + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;
  logic [NS-1:0] v_in;

  assign adv[NS-1] = !v_q[NS-1] || out_o.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign v_in = {v_q[NS-2:0], req_valid_i};
  assign req_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  logic [REM_W-1:0] rem_q [QBITS-1][3];
  logic [QBITS-1:0] q_q   [QBITS][3];
  logic [SUM_W-1:0] d_q   [QBITS];
  logic [2:0]       neg_q [QBITS];
  logic [2:0]       ovf_q [QBITS];
  logic             zero_q[QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [REM_W-1:0] rem_in [3];
    logic [REM_W-1:0] rem_d  [3];
    logic [QBITS-1:0] q_in   [3];
    logic [QBITS-1:0] q_d    [3];
    logic [REM_W-1:0] dsh;
    logic [SUM_W-1:0] d_in;
    logic [2:0]       neg_in, ovf_in;
    logic             zero_in;

    if (k == 0) begin : g_first
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = REM_W'({req_i.n_mag[j], {FRAC_SHIFT{1'b0}}});
        assign q_in[j]   = '0;
      end
      assign d_in    = req_i.d_mag;
      assign neg_in  = req_i.neg;
      assign ovf_in  = req_i.ovf;
      assign zero_in = req_i.zero;
    end else begin : g_next
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = rem_q[k-1][j];
        assign q_in[j]   = q_q[k-1][j];
      end
      assign d_in    = d_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    always_comb begin
      dsh = REM_W'(d_in) << (QBITS - 1 - k);
      for (int j = 0; j < 3; j++) begin
        if (rem_in[j] >= dsh) begin
          rem_d[j] = rem_in[j] - dsh;
          q_d[j]   = {q_in[j][QBITS-2:0], 1'b1};
        end else begin
          rem_d[j] = rem_in[j];
          q_d[j]   = {q_in[j][QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        for (int j = 0; j < 3; j++) begin
          q_q[k][j] <= q_d[j];
        end
        d_q[k]    <= d_in;
        neg_q[k]  <= neg_in;
        ovf_q[k]  <= ovf_in;
        zero_q[k] <= zero_in;
      end
    end

    if (k < QBITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          for (int j = 0; j < 3; j++) begin
            rem_q[k][j] <= rem_d[j];
          end
        end
      end
    end
  end

  // output stage
  weight_t w_d [3];
  weight_t w_q [3];
  logic    sing_q;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (zero_q[QBITS-1]) begin
        w_d[j] = '0;
      end else if (ovf_q[QBITS-1][j]) begin
        w_d[j] = neg_q[QBITS-1][j] ? SAT_NEG : SAT_POS;
      end else if (neg_q[QBITS-1][j]) begin
        w_d[j] = -$signed({1'b0, q_q[QBITS-1][j]});
      end else begin
        w_d[j] = $signed({1'b0, q_q[QBITS-1][j]});
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      for (int j = 0; j < 3; j++) begin
        w_q[j] <= w_d[j];
      end
      sing_q <= zero_q[QBITS-1];
    end
  end

  assign out_o.valid    = v_q[NS-1];
  assign out_o.weight_a = w_q[0];
  assign out_o.weight_b = w_q[1];
  assign out_o.weight_c = w_q[2];
  assign out_o.singular = sing_q;

endmodule

>>> src/barycentric_coordinate_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_coordinate_solver
// Solves M * w = T, M having the vertices as columns, by adjugate over
// determinant; weights are signed Q15.16, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled and returns one
// result per item, in order: six stages form the exact adjugate, determinant
// and numerators, and the divider spends one stage per quotient bit (31
// stages) plus an output register. Each stage holds its item only while the
// stage after it is full, so bubbles close up under back-pressure. A zero
// determinant gives singular set and all weights zero.
module barycentric_coordinate_solver import bcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcs_in_if.sink    in_i,
  bcs_out_if.source out_o
);

  div_req_t req;
  logic     req_valid;
  logic     req_ready;

  bcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  bcs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .out_o       (out_o)
  );

endmodule

>>> src/bcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks on the solver, bound to the top level.
// ----------------------------------------------------------------------------
module bcs_checker import bcs_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input weight_t weight_a_i,
  input weight_t weight_b_i,
  input weight_t weight_c_i,
  input logic    singular_i
);

  logic [7:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(weight_a_i) && $stable(weight_b_i)
                                    && $stable(weight_c_i) && $stable(singular_i))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without a pending item");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && singular_i |-> weight_a_i == '0 && weight_b_i == '0
                                  && weight_c_i == '0)
    else $error("singular result with nonzero weight");

endmodule

bind barycentric_coordinate_solver bcs_checker u_bcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .weight_a_i  (out_o.weight_a),
  .weight_b_i  (out_o.weight_b),
  .weight_c_i  (out_o.weight_c),
  .singular_i  (out_o.singular)
);
